// ===== design/udec_pkg.sv =====
// Shared types and constants for the unsigned to decimal ASCII converter.
package udec_pkg;

   localparam int VALUE_W  = 32;
   localparam int DIGITS   = 10;
   localparam int BCD_W    = 4 * DIGITS;
   localparam int BIT_CNT_W = $clog2(VALUE_W);
   localparam int CHAR_W   = 6;
   localparam int COUNT_W  = 4;
   localparam int IDX_W    = $clog2(DIGITS);

   localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(VALUE_W - 1);
   localparam logic [CHAR_W-1:0]    DIGIT_BASE = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_COUNT,
      ST_EMIT
   } udec_state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic count;
      logic emit;
   } udec_cmd_type;

   typedef struct packed {
      logic bit_done;
      logic last_digit;
      logic out_free;
   } udec_status_type;

endpackage

// ===== design/udec_if.sv =====
// Valid/ready channel interfaces for the request and response words.
interface udec_req_if import udec_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface udec_rsp_if import udec_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  digit_char;
   logic [COUNT_W-1:0] digit_count;
   logic               is_last;

   modport source (output valid, output digit_char, output digit_count, output is_last,
                   input ready);
   modport sink   (input valid, input digit_char, input digit_count, input is_last,
                   output ready);
endinterface

// ===== design/udec_ctrl.sv =====
// Sequencer for load, shift-and-add conversion, digit count and digit emission.
module udec_ctrl import udec_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid_i,
   output logic            req_ready_o,
   input  udec_status_type status_i,
   output udec_cmd_type    cmd_o
);

   udec_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_o       = '0;
      req_ready_o = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready_o = 1'b1;
            if (req_valid_i) begin
               cmd_o.load = 1'b1;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd_o.shift = 1'b1;
            if (status_i.bit_done) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd_o.count = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register can take the next digit
            if (status_i.out_free) begin
               cmd_o.emit = 1'b1;
               if (status_i.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/udec_dp.sv =====
// Datapath: binary shift register, BCD accumulator, digit counter and output register.
module udec_dp import udec_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  udec_cmd_type       cmd_i,
   output udec_status_type    status_o,
   input  logic [VALUE_W-1:0] value_i,
   output logic               rsp_valid_o,
   input  logic               rsp_ready_i,
   output logic [CHAR_W-1:0]  rsp_digit_char_o,
   output logic [COUNT_W-1:0] rsp_digit_count_o,
   output logic               rsp_is_last_o
);

   logic [VALUE_W-1:0]   bin_ff;
   logic [BCD_W-1:0]     bcd_ff;
   logic [BIT_CNT_W-1:0] bit_cnt_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 rsp_valid_ff;
   logic [CHAR_W-1:0]    char_ff;
   logic [COUNT_W-1:0]   out_count_ff;
   logic                 last_ff;

   logic [3:0]           bcd_digit [DIGITS];
   logic [BCD_W-1:0]     bcd_adj;
   logic [COUNT_W-1:0]   count_in;
   logic [3:0]           digit_sel;

   // split into digits and add 3 to any digit of 5 or more before the shift
   for (genvar i = 0; i < DIGITS; i++) begin : g_digit
      assign bcd_digit[i]        = bcd_ff[4*i +: 4];
      assign bcd_adj[4*i +: 4]   = (bcd_digit[i] >= 4'd5) ? bcd_digit[i] + 4'd3
                                                          : bcd_digit[i];
   end

   // position of the highest nonzero digit, at least one digit
   always_comb begin
      count_in = COUNT_W'(1);
      for (int i = 1; i < DIGITS; i++) begin
         if (bcd_digit[i] != 4'd0) begin
            count_in = COUNT_W'(i + 1);
         end
      end
   end

   assign digit_sel = bcd_digit[idx_ff];

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         bin_ff     <= value_i;
         bcd_ff     <= '0;
         bit_cnt_ff <= '0;
      end else if (cmd_i.shift) begin
         bin_ff     <= {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_ff     <= {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bit_cnt_ff <= bit_cnt_ff + 1'b1;
      end
      if (cmd_i.count) begin
         count_ff <= count_in;
         idx_ff   <= IDX_W'(count_in - 1'b1);
      end else if (cmd_i.emit) begin
         idx_ff   <= idx_ff - 1'b1;
      end
      if (cmd_i.emit) begin
         char_ff      <= DIGIT_BASE + CHAR_W'(digit_sel);
         out_count_ff <= count_ff;
         last_ff      <= (idx_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready_i) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status_o.bit_done   = (bit_cnt_ff == BIT_LAST);
   assign status_o.last_digit = (idx_ff == '0);
   assign status_o.out_free   = !rsp_valid_ff || rsp_ready_i;

   assign rsp_valid_o       = rsp_valid_ff;
   assign rsp_digit_char_o  = char_ff;
   assign rsp_digit_count_o = out_count_ff;
   assign rsp_is_last_o     = last_ff;

`ifndef SYNTHESIS
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd_i.emit |-> status_o.out_free)
      else $error("digit emitted while output register full");

   a_count_sets_idx: assert property (@(posedge clock) disable iff (reset)
      cmd_i.count |=> (COUNT_W'(idx_ff) == count_ff - 1'b1))
      else $error("digit index does not start at the top digit");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cmd_i.emit |-> (count_ff >= COUNT_W'(1) && count_ff <= COUNT_W'(DIGITS)))
      else $error("digit count out of range");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (char_ff >= DIGIT_BASE && char_ff <= DIGIT_BASE + 6'd9))
      else $error("emitted character is not a decimal digit");

   a_no_leading_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.emit && count_ff != COUNT_W'(1) && COUNT_W'(idx_ff) == count_ff - 1'b1)
      |-> (digit_sel != 4'd0))
      else $error("leading zero emitted");
`endif

endmodule

// ===== design/unsigned_to_decimal_ascii.sv =====
// Top level of the unsigned 32-bit binary to decimal ASCII converter.
//
// Usage:
//   req_port carries one 32-bit unsigned value per word. rsp_port returns the
//   decimal text of that value, one word per character, most significant digit
//   first, with no leading zeros (zero yields a single '0'). Each rsp word also
//   carries the total digit count (1 to 10) and is_last on the final digit.
//   Sequence: the value loads at the accepting edge, then one shift-and-add-3
//   step runs per input bit (one input bit per cycle through the BCD register),
//   the digits are counted, then one digit per cycle goes into the output
//   register while rsp does not stall. Most of the time per value goes to the
//   bit-serial BCD conversion.
//   req_port.ready is high only while idle; the next value is taken while the
//   last digit still waits in the output register.
//   Reset (synchronous, active high) returns the sequencer to idle and empties
//   the output register. When the receiver stalls, the current digit holds in
//   the output register and emission pauses until it is taken.
module unsigned_to_decimal_ascii import udec_pkg::*; (
   input logic         clock,
   input logic         reset,
   udec_req_if.sink    req_port,
   udec_rsp_if.source  rsp_port
);

   udec_cmd_type    cmd;
   udec_status_type status;

   // sequencer: drives commands, owns the request handshake
   udec_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid_i (req_port.valid),
      .req_ready_o (req_port.ready),
      .status_i    (status),
      .cmd_o       (cmd)
   );

   // datapath: conversion registers and the response output register
   udec_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd_i             (cmd),
      .status_o          (status),
      .value_i           (req_port.value),
      .rsp_valid_o       (rsp_port.valid),
      .rsp_ready_i       (rsp_port.ready),
      .rsp_digit_char_o  (rsp_port.digit_char),
      .rsp_digit_count_o (rsp_port.digit_count),
      .rsp_is_last_o     (rsp_port.is_last)
   );

endmodule
